>>> rtl/ilp_pkg.sv
// Package for the integer literal parser: widths, state and result types,
// character codes and the digit decode helpers. No dependencies.
package ilp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned PROD_W  = VALUE_W + 4;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SUFFIX = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_e;

  localparam logic [TYPE_W-1:0] TYPE_INT32  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_UINT32 = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_INT64  = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_UINT64 = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UP_U  = 8'h55;
  localparam logic [CHAR_W-1:0] CH_LO_U  = 8'h75;
  localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_LO_L  = 8'h6C;

  typedef struct packed {
    phase_e               phase;
    logic                 first_was_zero;
    radix_e               radix_sel;
    logic [VALUE_W-1:0]   accumulator;
    logic                 unsigned_flag;
    logic                 long_flag;
  } state_t;

  localparam state_t STATE_RST = '{
    phase:          PH_FIRST,
    first_was_zero: 1'b0,
    radix_sel:      RADIX_DEC,
    accumulator:    '0,
    unsigned_flag:  1'b0,
    long_flag:      1'b0
  };

  typedef struct packed {
    logic [VALUE_W-1:0] literal_value;
    logic [TYPE_W-1:0]  type_code;
  } result_t;

  function automatic logic is_dec(logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_lo_hex(logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_F);
  endfunction

  function automatic logic is_up_hex(logic [CHAR_W-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_F);
  endfunction

  function automatic logic digit_ok(logic [CHAR_W-1:0] c, radix_e r);
    logic ok;
    case (r)
      RADIX_HEX: ok = is_dec(c) || is_lo_hex(c) || is_up_hex(c);
      RADIX_BIN: ok = (c == CH_ZERO) || (c == CH_ONE);
      default:   ok = is_dec(c);
    endcase
    return ok;
  endfunction

  function automatic logic [3:0] digit_value(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if (is_lo_hex(c)) begin
      v = c - CH_LO_A + 8'd10;
    end else if (is_up_hex(c)) begin
      v = c - CH_UP_A + 8'd10;
    end else begin
      v = c - CH_ZERO;
    end
    return v[3:0];
  endfunction

endpackage

>>> rtl/ilp_if.sv
// Request channel interfaces of the integer literal parser: characters in,
// parsed literals out. Depends on ilp_pkg.
interface ilp_char_if;
  logic                        valid;
  logic                        ready;
  logic [ilp_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface ilp_lit_if;
  logic                        valid;
  logic                        ready;
  logic [ilp_pkg::VALUE_W-1:0] literal_value;
  logic [ilp_pkg::TYPE_W-1:0]  type_code;

  modport source (output valid, literal_value, type_code, input ready);
  modport sink   (input valid, literal_value, type_code, output ready);
endinterface

>>> rtl/ilp_step.sv
// Next-state and result logic for one character of the literal parser.
// Purely combinational. Depends on ilp_pkg.
module ilp_step (
  input  ilp_pkg::state_t            state_i,
  input  logic [ilp_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       last_char_i,
  output ilp_pkg::state_t            state_o,
  output ilp_pkg::result_t           result_o
);

  ilp_pkg::radix_e                   eff_radix;
  logic [ilp_pkg::PROD_W-1:0]        scaled;
  logic [ilp_pkg::PROD_W-1:0]        sum;
  logic [ilp_pkg::VALUE_W-1:0]       acc_dig;
  logic                              dig_ok;
  logic                              is_u;
  logic                              is_l;
  logic                              is_x;
  logic                              is_b;
  ilp_pkg::state_t                   td;
  ilp_pkg::state_t                   nxt;
  logic [ilp_pkg::VALUE_W-1:0]       v;

  assign eff_radix = (state_i.phase == ilp_pkg::PH_FIRST) ? ilp_pkg::RADIX_DEC
                                                          : state_i.radix_sel;
  assign is_u = (char_code_i == ilp_pkg::CH_LO_U) || (char_code_i == ilp_pkg::CH_UP_U);
  assign is_l = (char_code_i == ilp_pkg::CH_LO_L) || (char_code_i == ilp_pkg::CH_UP_L);
  assign is_x = (char_code_i == ilp_pkg::CH_LO_X) || (char_code_i == ilp_pkg::CH_UP_X);
  assign is_b = (char_code_i == ilp_pkg::CH_LO_B) || (char_code_i == ilp_pkg::CH_UP_B);
  assign dig_ok = ilp_pkg::digit_ok(char_code_i, eff_radix);

  // acc * base as shifts, then + digit; any carry into the top nibble saturates
  always_comb begin
    case (eff_radix)
      ilp_pkg::RADIX_HEX: scaled = {state_i.accumulator, 4'b0000};
      ilp_pkg::RADIX_BIN: scaled = {3'b000, state_i.accumulator, 1'b0};
      default:            scaled = {1'b0, state_i.accumulator, 3'b000}
                                 + {3'b000, state_i.accumulator, 1'b0};
    endcase
  end

  assign sum     = scaled + {{(ilp_pkg::PROD_W-4){1'b0}}, ilp_pkg::digit_value(char_code_i)};
  assign acc_dig = (sum[ilp_pkg::PROD_W-1:ilp_pkg::VALUE_W] != '0) ? '1
                                                               : sum[ilp_pkg::VALUE_W-1:0];

  always_comb begin
    td           = state_i;
    td.radix_sel = eff_radix;
    if (dig_ok) begin
      td.accumulator = acc_dig;
      td.phase       = ilp_pkg::PH_DIGITS;
    end else begin
      td.phase         = ilp_pkg::PH_SUFFIX;
      td.unsigned_flag = state_i.unsigned_flag | is_u;
      td.long_flag     = state_i.long_flag | is_l;
    end
  end

  always_comb begin
    nxt = state_i;
    unique case (state_i.phase)
      ilp_pkg::PH_FIRST: begin
        nxt                = td;
        nxt.radix_sel      = ilp_pkg::RADIX_DEC;
        nxt.first_was_zero = (char_code_i == ilp_pkg::CH_ZERO);
        if (td.phase == ilp_pkg::PH_DIGITS) begin
          nxt.phase = ilp_pkg::PH_SECOND;
        end
      end
      ilp_pkg::PH_SECOND: begin
        if (state_i.first_was_zero && !last_char_i && is_x) begin
          nxt.radix_sel = ilp_pkg::RADIX_HEX;
          nxt.phase     = ilp_pkg::PH_DIGITS;
        end else if (state_i.first_was_zero && !last_char_i && is_b) begin
          nxt.radix_sel = ilp_pkg::RADIX_BIN;
          nxt.phase     = ilp_pkg::PH_DIGITS;
        end else begin
          nxt = td;
        end
      end
      ilp_pkg::PH_DIGITS: begin
        nxt = td;
      end
      ilp_pkg::PH_SUFFIX: begin
        nxt.unsigned_flag = state_i.unsigned_flag | is_u;
        nxt.long_flag     = state_i.long_flag | is_l;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign v = nxt.accumulator;

  always_comb begin
    result_o.literal_value = v;
    if (!nxt.long_flag && !nxt.unsigned_flag) begin
      if (v[ilp_pkg::VALUE_W-1:31] == '0) begin
        result_o.type_code = ilp_pkg::TYPE_INT32;
      end else if (!v[ilp_pkg::VALUE_W-1]) begin
        result_o.type_code = ilp_pkg::TYPE_INT64;
      end else begin
        result_o.type_code = ilp_pkg::TYPE_UINT64;
      end
    end else if (!nxt.long_flag) begin
      result_o.type_code = (v[ilp_pkg::VALUE_W-1:32] == '0) ? ilp_pkg::TYPE_UINT32
                                                           : ilp_pkg::TYPE_UINT64;
    end else if (!nxt.unsigned_flag) begin
      result_o.type_code = !v[ilp_pkg::VALUE_W-1] ? ilp_pkg::TYPE_INT64
                                                  : ilp_pkg::TYPE_UINT64;
    end else begin
      result_o.type_code = ilp_pkg::TYPE_UINT64;
    end
  end

  assign state_o = last_char_i ? ilp_pkg::STATE_RST : nxt;

endmodule

>>> rtl/integer_literal_parser.sv
// Top level of the integer literal parser: parse state register, result
// register with skid entry, request handshakes. Depends on ilp_pkg, ilp_if,
// ilp_step.
//
//   channel  dir  payload                       request
//   chr_i    in   char_code[7:0], last_char     one token character
//   lit_o    out  literal_value[63:0], type[1:0] one parsed literal per token
//
// One character is taken per cycle while chr_i is ready; the parse state updates at the accept.
// A token's literal goes to the output register, or to skid if that is full.
// A two-entry result buffer (output register plus skid) keeps chr_i open while
// one literal waits; chr_i stalls only when both entries are full.
// Reset clears the parse state and empties the result buffer.
module integer_literal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilp_char_if.sink    chr_i,
  ilp_lit_if.source   lit_o
);

  ilp_pkg::state_t  state_q, state_d;
  ilp_pkg::result_t step_res;
  ilp_pkg::result_t main_q, skid_q;
  logic             main_valid_q, skid_valid_q;
  logic             accept, push, pop;

  ilp_step u_step (
    .state_i     (state_q),
    .char_code_i (chr_i.char_code),
    .last_char_i (chr_i.last_char),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  assign chr_i.ready = !skid_valid_q;
  assign accept      = chr_i.valid && chr_i.ready;
  assign push        = accept && chr_i.last_char;
  assign pop         = main_valid_q && lit_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilp_pkg::STATE_RST;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : step_res;
    end
    if (push && main_valid_q && !pop) begin
      skid_q <= step_res;
    end
  end

  assign lit_o.valid         = main_valid_q;
  assign lit_o.literal_value = main_q.literal_value;
  assign lit_o.type_code     = main_q.type_code;

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry full while output register empty");

  a_last_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> lit_o.valid)
    else $error("last character accepted but no literal presented");

  a_last_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (state_q.phase == ilp_pkg::PH_FIRST) && (state_q.accumulator == '0)
             && !state_q.unsigned_flag && !state_q.long_flag)
    else $error("parse state not cleared after end of token");
`endif

endmodule
